FILE: hw/rtl/bps_pkg.sv
// Shared types and constants of the Blinn-Phong fragment shade core.
`default_nettype none

package bps_pkg;

   localparam int FRAC_W     = 14;
   localparam int NORM_W     = 16;
   localparam int POS_W      = 24;
   localparam int DIFF_W     = POS_W + 1;
   localparam int COLOR_W    = 8;
   localparam int SHINE_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int FIFO_DEPTH = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHININESS = 3'd6;

   // Shading constants, Q0.16 and Q.14
   localparam longint ONE_Q14    = 16384;
   localparam longint POW_CAP    = 262144;
   localparam longint K_AMB      = 22938;
   localparam longint K_DIF      = 58982;
   localparam longint K_SPEC     = 7864;
   localparam longint AMB_TERM   = K_AMB * ONE_Q14;
   localparam longint SPEC_SCALE = 255 * K_SPEC;
   localparam longint ROUND_HALF = 64'd1 << 29;

   typedef struct packed {
      logic [2:0][POS_W-1:0] eye;
      logic [2:0][POS_W-1:0] light;
   } scene_type;

   // One fragment between the front end and the shading pipeline
   typedef struct packed {
      logic [2:0][DIFF_W-1:0]  light_dir;
      logic [2:0][DIFF_W-1:0]  eye_dir;
      logic [2:0][NORM_W-1:0]  normal;
      logic [2:0][COLOR_W-1:0] tex;
   } frag_type;

endpackage

`default_nettype wire

FILE: hw/rtl/blinn_phong_fragment_shade_core.sv
// Throughput: one fragment per cycle unless rsp_stall holds the output.
// The pipelined square roots and dividers take an item each cycle while the pipeline advances.
// The pipeline depth comes mainly from the 25- and 16-stage square roots and two 15-stage divider rows.
// Reset (synchronous, active high) empties the queue and pipeline and loads register defaults:
// eye at the origin, light at (0, 2.0, 2.0), shininess 150.
`default_nettype none

module blinn_phong_fragment_shade_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_wr_en,
   input  logic [bps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bps_pkg::POS_W-1:0]             csr_wr_data,
   // fragment input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bps_pkg::NORM_W-1:0]     req_normal_x,
   input  logic signed [bps_pkg::NORM_W-1:0]     req_normal_y,
   input  logic signed [bps_pkg::NORM_W-1:0]     req_normal_z,
   input  logic signed [bps_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [bps_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [bps_pkg::POS_W-1:0]      req_pos_z,
   input  logic [bps_pkg::COLOR_W-1:0]           req_tex_red,
   input  logic [bps_pkg::COLOR_W-1:0]           req_tex_green,
   input  logic [bps_pkg::COLOR_W-1:0]           req_tex_blue,
   // shaded color output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bps_pkg::COLOR_W-1:0]           rsp_out_red,
   output logic [bps_pkg::COLOR_W-1:0]           rsp_out_green,
   output logic [bps_pkg::COLOR_W-1:0]           rsp_out_blue
);

   // Scene registers. The front end reads eye and light when it takes an item;
   // the power stages read shininess as the item passes, so registers must only
   // change while the core is empty; the core itself does not enforce this.
   bps_pkg::scene_type              scene_ff;
   logic [bps_pkg::SHINE_W-1:0]     shininess_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scene_ff.eye[0]   <= '0;
         scene_ff.eye[1]   <= '0;
         scene_ff.eye[2]   <= '0;
         scene_ff.light[0] <= '0;
         scene_ff.light[1] <= 24'h020000;
         scene_ff.light[2] <= 24'h020000;
         shininess_ff      <= 8'd150;
      end else if (csr_wr_en) begin
         case (csr_index)
            bps_pkg::CSR_EYE_X:     scene_ff.eye[0]   <= csr_wr_data;
            bps_pkg::CSR_EYE_Y:     scene_ff.eye[1]   <= csr_wr_data;
            bps_pkg::CSR_EYE_Z:     scene_ff.eye[2]   <= csr_wr_data;
            bps_pkg::CSR_LIGHT_X:   scene_ff.light[0] <= csr_wr_data;
            bps_pkg::CSR_LIGHT_Y:   scene_ff.light[1] <= csr_wr_data;
            bps_pkg::CSR_LIGHT_Z:   scene_ff.light[2] <= csr_wr_data;
            bps_pkg::CSR_SHININESS: shininess_ff      <= csr_wr_data[bps_pkg::SHINE_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // Front end -> queue -> shading pipeline. The four-entry queue lets the front
   // keep taking items after the output side stalls, until the queue is full.
   logic              fifo_full;
   logic              push;
   bps_pkg::frag_type push_data;
   logic              head_valid;
   bps_pkg::frag_type head_data;
   logic              pop;

   bps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .scene         (scene_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_normal_x  (req_normal_x),
      .req_normal_y  (req_normal_y),
      .req_normal_z  (req_normal_z),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_tex_red   (req_tex_red),
      .req_tex_green (req_tex_green),
      .req_tex_blue  (req_tex_blue),
      .fifo_full     (fifo_full),
      .push          (push),
      .push_data     (push_data)
   );

   bps_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // The back pipeline advances as one unit whenever its output register is
   // free or being taken, so it holds all items in place while a valid output meets rsp_stall.
   bps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .shininess     (shininess_ff),
      .head_valid    (head_valid),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/bps_delay.sv
// Enabled shift line that carries side data alongside the arithmetic units.
`default_nettype none

module bps_delay #(
   parameter int W = 8,
   parameter int L = 4
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] sr_ff [L];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= din;
         for (int k = 1; k < L; k++) begin
            sr_ff[k] <= sr_ff[k-1];
         end
      end
   end

   assign dout = sr_ff[L-1];

endmodule

`default_nettype wire

FILE: hw/rtl/bps_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module bps_isqrt #(
   parameter int IW = 32
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IW-1:0]     rad,
   output logic [IW/2-1:0]   root
);

   localparam int OW = IW / 2;
   localparam int RW = OW + 2;

   logic [IW-1:0] x_ff   [OW];
   logic [RW-1:0] rem_ff [OW];
   logic [OW-1:0] q_ff   [OW];

   for (genvar k = 0; k < OW; k++) begin : g_stage
      logic [IW-1:0] x_cur;
      logic [RW-1:0] rem_cur;
      logic [OW-1:0] q_cur;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign x_cur   = rad;
         assign rem_cur = '0;
         assign q_cur   = '0;
      end else begin : g_next
         assign x_cur   = x_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign q_cur   = q_ff[k-1];
      end

      // remainder stays below 2^OW before the shift, so the top bits drop safely
      assign rem_sh = {rem_cur[RW-3:0], x_cur[IW-1 -: 2]};
      assign trial  = {q_cur, 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]   <= x_cur << 2;
            rem_ff[k] <= ge ? rem_sh - trial : rem_sh;
            q_ff[k]   <= {q_cur[OW-2:0], ge};
         end
      end
   end

   assign root = q_ff[OW-1];

endmodule

`default_nettype wire

FILE: hw/rtl/bps_udiv.sv
// Pipelined restoring divider: (mag << 14) / len, quotient known to be at most 1.0.
`default_nettype none

module bps_udiv #(
   parameter int MW = 16,
   parameter int LW = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [MW-1:0]             mag,
   input  logic [LW-1:0]             len,
   output logic [bps_pkg::FRAC_W:0]  quo
);

   localparam int QW = bps_pkg::FRAC_W + 1;
   localparam int RW = LW + QW;

   logic [RW-1:0] rem_ff [QW];
   logic [LW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int SH = QW - 1 - k;
      logic [RW-1:0] rem_cur;
      logic [LW-1:0] den_cur;
      logic [QW-1:0] quo_cur;
      logic [RW-1:0] den_sh;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_cur = RW'({mag, {bps_pkg::FRAC_W{1'b0}}});
         assign den_cur = len;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      assign den_sh = RW'(den_cur) << SH;
      assign ge     = rem_cur >= den_sh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? rem_cur - den_sh : rem_cur;
            den_ff[k] <= den_cur;
            quo_ff[k] <= {quo_cur[QW-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

`default_nettype wire

FILE: hw/rtl/bps_fifo.sv
// Short fragment queue between the front end and the shading pipeline.
`default_nettype none

module bps_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bps_pkg::frag_type push_data,
   output logic              full,
   output logic              head_valid,
   output bps_pkg::frag_type head_data,
   input  logic              pop
);

   localparam int AW = $clog2(bps_pkg::FIFO_DEPTH);

   bps_pkg::frag_type mem_ff [bps_pkg::FIFO_DEPTH];
   logic [AW-1:0]     wr_ptr_ff;
   logic [AW-1:0]     rd_ptr_ff;
   logic [AW:0]       count_ff;

   assign full       = count_ff == (AW+1)'(bps_pkg::FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (AW+1)'(1);
            2'b01:   count_ff <= count_ff - (AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bps_front.sv
// Front end: accept a fragment and form its light and eye difference vectors.
`default_nettype none

module bps_front (
   input  logic                              clock,
   input  logic                              reset,
   input  bps_pkg::scene_type                scene,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [bps_pkg::NORM_W-1:0] req_normal_x,
   input  logic signed [bps_pkg::NORM_W-1:0] req_normal_y,
   input  logic signed [bps_pkg::NORM_W-1:0] req_normal_z,
   input  logic signed [bps_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [bps_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [bps_pkg::POS_W-1:0]  req_pos_z,
   input  logic [bps_pkg::COLOR_W-1:0]       req_tex_red,
   input  logic [bps_pkg::COLOR_W-1:0]       req_tex_green,
   input  logic [bps_pkg::COLOR_W-1:0]       req_tex_blue,
   input  logic                              fifo_full,
   output logic                              push,
   output bps_pkg::frag_type                 push_data
);

   logic [2:0][bps_pkg::POS_W-1:0] pos;
   bps_pkg::frag_type              frag_in;
   bps_pkg::frag_type              frag_ff;
   logic                           valid_ff;
   logic                           load;

   assign pos = {req_pos_z, req_pos_y, req_pos_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // sign-extend both sides; the difference always fits 25 bits
         frag_in.light_dir[i] = {scene.light[i][bps_pkg::POS_W-1], scene.light[i]}
                              - {pos[i][bps_pkg::POS_W-1], pos[i]};
         frag_in.eye_dir[i]   = {scene.eye[i][bps_pkg::POS_W-1], scene.eye[i]}
                              - {pos[i][bps_pkg::POS_W-1], pos[i]};
      end
      frag_in.normal = {req_normal_z, req_normal_y, req_normal_x};
      frag_in.tex    = {req_tex_blue, req_tex_green, req_tex_red};
   end

   // hold the staged item while the queue is full
   assign req_stall = valid_ff && fifo_full;
   assign load      = !req_stall;
   assign push      = valid_ff && !fifo_full;
   assign push_data = frag_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         frag_ff <= frag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_valid;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bps_back.sv
// Shading pipeline: normalize, dot products, specular power, color combine.
`default_nettype none

module bps_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [bps_pkg::SHINE_W-1:0]        shininess,
   input  logic                               head_valid,
   input  bps_pkg::frag_type                  head_data,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bps_pkg::COLOR_W-1:0]        rsp_out_red,
   output logic [bps_pkg::COLOR_W-1:0]        rsp_out_green,
   output logic [bps_pkg::COLOR_W-1:0]        rsp_out_blue
);

   localparam int DW   = bps_pkg::DIFF_W;
   localparam int MW   = DW - 1;
   localparam int SQW  = 2 * MW;
   localparam int LSW  = SQW + 2;
   localparam int LW   = LSW / 2;
   localparam int QW   = bps_pkg::FRAC_W + 1;
   localparam int UW   = QW + 1;
   localparam int HW   = UW + 1;
   localparam int HMW  = UW;
   localparam int HSW  = 2 * HMW;
   localparam int HLW  = HSW / 2;
   localparam int PW   = bps_pkg::NORM_W + UW;
   localparam int DSW  = PW + 2;
   localparam int DLW  = 17;
   localparam int BW   = 19;
   localparam int FW   = 33;
   localparam int SPW  = 40;
   localparam int CW   = 42;
   localparam int CHW  = CW - 30;
   localparam int NPOW = bps_pkg::SHINE_W;
   localparam int LAT  = 3 + LW + QW + 3 + HLW + QW + 2 + NPOW + 2;

   typedef logic [2:0][bps_pkg::NORM_W-1:0]  nvec_type;
   typedef logic [2:0][bps_pkg::COLOR_W-1:0] tvec_type;

   typedef struct packed {
      logic [2:0][MW-1:0] lmag;
      logic [2:0][MW-1:0] emag;
      logic [2:0]         lneg;
      logic [2:0]         eneg;
      nvec_type           normal;
      tvec_type           tex;
   } side1_type;

   typedef struct packed {
      logic [2:0] lneg;
      logic [2:0] eneg;
      logic       lzero;
      logic       ezero;
      nvec_type   normal;
      tvec_type   tex;
   } side2_type;

   typedef struct packed {
      logic [2:0][HMW-1:0] hmag;
      logic [2:0]          hneg;
      logic [DLW-1:0]      dl;
      nvec_type            normal;
      tvec_type            tex;
   } side3_type;

   typedef struct packed {
      logic [2:0]     hneg;
      logic           hzero;
      logic [DLW-1:0] dl;
      nvec_type       normal;
      tvec_type       tex;
   } side4_type;

   function automatic logic [MW-1:0] abs_diff(input logic [DW-1:0] d);
      logic [DW-1:0] t;
      t = d[DW-1] ? (~d + DW'(1)) : d;
      return t[MW-1:0];
   endfunction

   function automatic logic [UW-1:0] apply_sign(input logic [QW-1:0] q, input logic neg,
                                                input logic zero);
      logic [UW-1:0] t;
      t = {1'b0, q};
      if (zero) begin
         return '0;
      end
      return neg ? (~t + UW'(1)) : t;
   endfunction

   function automatic logic [PW-1:0] smul(input logic [bps_pkg::NORM_W-1:0] n,
                                          input logic [UW-1:0] u);
      logic signed [PW-1:0] p;
      p = $signed(n) * $signed(u);
      return p;
   endfunction

   // clamp a dot product at zero and drop 14 fraction bits
   function automatic logic [DLW-1:0] clamp_dot(input logic [2:0][PW-1:0] p);
      logic [DSW-1:0] s;
      s = DSW'($signed(p[0])) + DSW'($signed(p[1])) + DSW'($signed(p[2]));
      if (s[DSW-1] || s == '0) begin
         return '0;
      end
      return s[bps_pkg::FRAC_W +: DLW];
   endfunction

   function automatic logic [BW-1:0] mul_sat(input logic [BW-1:0] a, input logic [BW-1:0] b);
      logic [2*BW-1:0] p;
      p = (2*BW)'(a) * (2*BW)'(b);
      if (p[2*BW-1:bps_pkg::FRAC_W] > (2*BW-bps_pkg::FRAC_W)'(bps_pkg::POW_CAP)) begin
         return BW'(bps_pkg::POW_CAP);
      end
      return p[bps_pkg::FRAC_W +: BW];
   endfunction

   // ---------------------------------------------------------------- control
   logic           adv;
   logic [LAT-1:0] vld_ff;
   logic           rsp_valid_ff;

   // the whole pipeline advances whenever the output register can take an item
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && head_valid;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAT-2:0], head_valid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   // ---------------------------------------------------------- s0 .. s2
   bps_pkg::frag_type  s0_frag_ff;
   side1_type          s1_side_ff;
   logic [2:0][SQW-1:0] s1_lsq_ff;
   logic [2:0][SQW-1:0] s1_esq_ff;
   side1_type          s1_side_in;
   side1_type          s2_side_ff;
   logic [LSW-1:0]     s2_lsum_ff;
   logic [LSW-1:0]     s2_esum_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_side_in.lmag[i] = abs_diff(s0_frag_ff.light_dir[i]);
         s1_side_in.emag[i] = abs_diff(s0_frag_ff.eye_dir[i]);
         s1_side_in.lneg[i] = s0_frag_ff.light_dir[i][DW-1];
         s1_side_in.eneg[i] = s0_frag_ff.eye_dir[i][DW-1];
      end
      s1_side_in.normal = s0_frag_ff.normal;
      s1_side_in.tex    = s0_frag_ff.tex;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_frag_ff <= head_data;
         s1_side_ff <= s1_side_in;
         for (int i = 0; i < 3; i++) begin
            s1_lsq_ff[i] <= SQW'(s1_side_in.lmag[i]) * SQW'(s1_side_in.lmag[i]);
            s1_esq_ff[i] <= SQW'(s1_side_in.emag[i]) * SQW'(s1_side_in.emag[i]);
         end
         s2_side_ff <= s1_side_ff;
         s2_lsum_ff <= LSW'(s1_lsq_ff[0]) + LSW'(s1_lsq_ff[1]) + LSW'(s1_lsq_ff[2]);
         s2_esum_ff <= LSW'(s1_esq_ff[0]) + LSW'(s1_esq_ff[1]) + LSW'(s1_esq_ff[2]);
      end
   end

   // ------------------------------------------- light / eye normalization
   logic [LW-1:0]      l_len;
   logic [LW-1:0]      e_len;
   side1_type          side1_out;
   side2_type          side2_in;
   side2_type          side2_out;
   logic [2:0][QW-1:0] l_quo;
   logic [2:0][QW-1:0] e_quo;

   bps_isqrt #(.IW(LSW)) u_lsqrt (
      .clock (clock), .en (adv), .rad (s2_lsum_ff), .root (l_len)
   );

   bps_isqrt #(.IW(LSW)) u_esqrt (
      .clock (clock), .en (adv), .rad (s2_esum_ff), .root (e_len)
   );

   bps_delay #(.W($bits(side1_type)), .L(LW)) u_side1 (
      .clock (clock), .en (adv), .din (s2_side_ff), .dout (side1_out)
   );

   for (genvar i = 0; i < 3; i++) begin : g_ldiv
      bps_udiv #(.MW(MW), .LW(LW)) u_ldiv (
         .clock (clock), .en (adv), .mag (side1_out.lmag[i]), .len (l_len), .quo (l_quo[i])
      );
      bps_udiv #(.MW(MW), .LW(LW)) u_ediv (
         .clock (clock), .en (adv), .mag (side1_out.emag[i]), .len (e_len), .quo (e_quo[i])
      );
   end

   always_comb begin
      side2_in.lneg   = side1_out.lneg;
      side2_in.eneg   = side1_out.eneg;
      side2_in.lzero  = l_len == '0;
      side2_in.ezero  = e_len == '0;
      side2_in.normal = side1_out.normal;
      side2_in.tex    = side1_out.tex;
   end

   bps_delay #(.W($bits(side2_type)), .L(QW)) u_side2 (
      .clock (clock), .en (adv), .din (side2_in), .dout (side2_out)
   );

   // ---------------------------------------------------- h1 .. h3
   logic [2:0][UW-1:0]  lu;
   logic [2:0][UW-1:0]  eu;
   logic [2:0][HW-1:0]  h1_hd_ff;
   logic [2:0][PW-1:0]  h1_pl_ff;
   nvec_type            h1_normal_ff;
   tvec_type            h1_tex_ff;
   side3_type           h2_side_in;
   side3_type           h2_side_ff;
   logic [2:0][HSW-1:0] h2_sq_ff;
   side3_type           h3_side_ff;
   logic [HSW-1:0]      h3_sum_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lu[i] = apply_sign(l_quo[i], side2_out.lneg[i], side2_out.lzero);
         eu[i] = apply_sign(e_quo[i], side2_out.eneg[i], side2_out.ezero);
      end
   end

   always_comb begin
      logic [HW-1:0] t;
      for (int i = 0; i < 3; i++) begin
         h2_side_in.hneg[i] = h1_hd_ff[i][HW-1];
         t = h1_hd_ff[i][HW-1] ? (~h1_hd_ff[i] + HW'(1)) : h1_hd_ff[i];
         h2_side_in.hmag[i] = t[HMW-1:0];
      end
      h2_side_in.dl     = clamp_dot(h1_pl_ff);
      h2_side_in.normal = h1_normal_ff;
      h2_side_in.tex    = h1_tex_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            h1_hd_ff[i] <= {lu[i][UW-1], lu[i]} + {eu[i][UW-1], eu[i]};
            h1_pl_ff[i] <= smul(side2_out.normal[i], lu[i]);
            h2_sq_ff[i] <= HSW'(h2_side_in.hmag[i]) * HSW'(h2_side_in.hmag[i]);
         end
         h1_normal_ff <= side2_out.normal;
         h1_tex_ff    <= side2_out.tex;
         h2_side_ff   <= h2_side_in;
         h3_side_ff   <= h2_side_ff;
         h3_sum_ff    <= h2_sq_ff[0] + h2_sq_ff[1] + h2_sq_ff[2];
      end
   end

   // -------------------------------------------- half vector normalization
   logic [HLW-1:0]     h_len;
   side3_type          side3_out;
   side4_type          side4_in;
   side4_type          side4_out;
   logic [2:0][QW-1:0] h_quo;

   bps_isqrt #(.IW(HSW)) u_hsqrt (
      .clock (clock), .en (adv), .rad (h3_sum_ff), .root (h_len)
   );

   bps_delay #(.W($bits(side3_type)), .L(HLW)) u_side3 (
      .clock (clock), .en (adv), .din (h3_side_ff), .dout (side3_out)
   );

   for (genvar i = 0; i < 3; i++) begin : g_hdiv
      bps_udiv #(.MW(HMW), .LW(HLW)) u_hdiv (
         .clock (clock), .en (adv), .mag (side3_out.hmag[i]), .len (h_len), .quo (h_quo[i])
      );
   end

   always_comb begin
      side4_in.hneg   = side3_out.hneg;
      side4_in.hzero  = h_len == '0;
      side4_in.dl     = side3_out.dl;
      side4_in.normal = side3_out.normal;
      side4_in.tex    = side3_out.tex;
   end

   bps_delay #(.W($bits(side4_type)), .L(QW)) u_side4 (
      .clock (clock), .en (adv), .din (side4_in), .dout (side4_out)
   );

   // ---------------------------------------------------------- d1 .. d2
   logic [2:0][PW-1:0] d1_ph_ff;
   logic [DLW-1:0]     d1_dl_ff;
   tvec_type           d1_tex_ff;
   logic [BW-1:0]      d2_base_ff;
   logic [DLW-1:0]     d2_dl_ff;
   tvec_type           d2_tex_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d1_ph_ff[i] <= smul(side4_out.normal[i],
                                apply_sign(h_quo[i], side4_out.hneg[i], side4_out.hzero));
         end
         d1_dl_ff   <= side4_out.dl;
         d1_tex_ff  <= side4_out.tex;
         // the clamped dot stays below the 16.0 cap, so the base needs no clamp
         d2_base_ff <= BW'(clamp_dot(d1_ph_ff));
         d2_dl_ff   <= d1_dl_ff;
         d2_tex_ff  <= d1_tex_ff;
      end
   end

   // ------------------------------------ specular power, one exponent bit a stage
   logic [BW-1:0]  pw_r_ff   [NPOW];
   logic [BW-1:0]  pw_b_ff   [NPOW];
   logic [DLW-1:0] pw_dl_ff  [NPOW];
   tvec_type       pw_tex_ff [NPOW];

   for (genvar k = 0; k < NPOW; k++) begin : g_pow
      logic [BW-1:0]  r_cur;
      logic [BW-1:0]  b_cur;
      logic [DLW-1:0] dl_cur;
      tvec_type       tex_cur;

      if (k == 0) begin : g_first
         assign r_cur   = BW'(bps_pkg::ONE_Q14);
         assign b_cur   = d2_base_ff;
         assign dl_cur  = d2_dl_ff;
         assign tex_cur = d2_tex_ff;
      end else begin : g_next
         assign r_cur   = pw_r_ff[k-1];
         assign b_cur   = pw_b_ff[k-1];
         assign dl_cur  = pw_dl_ff[k-1];
         assign tex_cur = pw_tex_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pw_r_ff[k]   <= shininess[k] ? mul_sat(r_cur, b_cur) : r_cur;
            pw_b_ff[k]   <= mul_sat(b_cur, b_cur);
            pw_dl_ff[k]  <= dl_cur;
            pw_tex_ff[k] <= tex_cur;
         end
      end
   end

   // -------------------------------------------------------- color combine
   logic [FW-1:0]      f1_fac_ff;
   logic [SPW-1:0]     f1_sp_ff;
   tvec_type           f1_tex_ff;
   logic [2:0][CW-1:0] f2_c_ff;
   logic [2:0][bps_pkg::COLOR_W-1:0] chan_in;
   logic [2:0][bps_pkg::COLOR_W-1:0] chan_ff;

   always_comb begin
      logic [CHW-1:0] v;
      for (int i = 0; i < 3; i++) begin
         v = f2_c_ff[i][CW-1 -: CHW];
         chan_in[i] = (v > CHW'(255)) ? 8'hFF : v[bps_pkg::COLOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_fac_ff <= FW'(bps_pkg::AMB_TERM)
                    + FW'(bps_pkg::K_DIF) * FW'(pw_dl_ff[NPOW-1]);
         f1_sp_ff  <= SPW'(bps_pkg::SPEC_SCALE) * SPW'(pw_r_ff[NPOW-1]);
         f1_tex_ff <= pw_tex_ff[NPOW-1];
         for (int i = 0; i < 3; i++) begin
            f2_c_ff[i] <= CW'(f1_tex_ff[i]) * CW'(f1_fac_ff) + CW'(f1_sp_ff)
                        + CW'(bps_pkg::ROUND_HALF);
         end
         chan_ff <= chan_in;
      end
   end

   assign rsp_out_red   = chan_ff[0];
   assign rsp_out_green = chan_ff[1];
   assign rsp_out_blue  = chan_ff[2];

endmodule

`default_nettype wire
